// ----- rtl/dqu_pkg.sv -----
// Shared types and constants of the double-ended queue unit.
package dqu_pkg;

   // Fixed field widths of the request and response words.
   localparam int IN_ITEM_BITS   = 16;
   localparam int ACTION_BITS    = 3;
   localparam int OUT_ITEM_BITS  = 16;
   localparam int OUT_COUNT_BITS = 5;

   // Operation codes carried on req_tuser.
   typedef enum logic [ACTION_BITS-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_STATUS     = 3'd4
   } action_type;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   // Flags reported by the pointer logic for the last operation.
   typedef struct packed {
      logic empty;
      logic full;
      logic rejected;
   } dqu_status_type;

endpackage

// ----- rtl/dqu_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module dqu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_a_addr,
   output logic [WIDTH-1:0] rd_a_data,
   input  logic [AW-1:0]    rd_b_addr,
   output logic [WIDTH-1:0] rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write port and both registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ----- rtl/dqu_ptr.sv -----
// Ring pointer and fill count logic of the double-ended queue.
module dqu_ptr #(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    op_valid,
   input  dqu_pkg::action_type     action,
   output logic                    wr_en,
   output logic [AW-1:0]           wr_addr,
   output logic [AW-1:0]           front_addr,
   output logic [AW-1:0]           back_addr,
   output logic [CW-1:0]           count,
   output dqu_pkg::dqu_status_type status
);
   import dqu_pkg::*;

   localparam int SW = CW + 1;

   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rejected_ff, rejected_in;

   logic          is_full;
   logic          is_empty;
   logic [AW-1:0] front_dec;
   logic [AW-1:0] front_inc;
   logic [SW-1:0] tail_sum;
   logic [AW-1:0] tail;

   // Wrapped neighbors of the front and the first free slot past the back.
   always_comb begin
      is_full   = (count_ff == CW'(DEPTH));
      is_empty  = (count_ff == '0);
      front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
      front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
      tail_sum  = SW'(front_ff) + SW'(count_ff);
      tail      = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
   end

   // Update of pointers, count and slot write for one operation.
   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      rejected_in = rejected_ff;
      wr_en       = 1'b0;
      wr_addr     = tail;
      if (op_valid) begin
         rejected_in = 1'b0;
         unique case (action)
            ACT_PUSH_FRONT: begin
               if (is_full) begin
                  rejected_in = 1'b1;
               end else begin
                  front_in = front_dec;
                  count_in = count_ff + CW'(1);
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
               end
            end
            ACT_PUSH_BACK: begin
               if (is_full) begin
                  rejected_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
                  wr_en    = 1'b1;
               end
            end
            ACT_POP_FRONT: begin
               if (is_empty) begin
                  rejected_in = 1'b1;
               end else begin
                  front_in = front_inc;
                  count_in = count_ff - CW'(1);
               end
            end
            ACT_POP_BACK: begin
               if (is_empty) begin
                  rejected_in = 1'b1;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            default: begin
               // Status only, and the unused codes behave the same way.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         count_ff    <= '0;
         rejected_ff <= 1'b0;
      end else begin
         front_ff    <= front_in;
         count_ff    <= count_in;
         rejected_ff <= rejected_in;
      end
   end

   // Read addresses for the result: the front slot and the slot before the tail.
   assign front_addr      = front_ff;
   assign back_addr       = (tail == '0) ? AW'(DEPTH - 1) : tail - AW'(1);
   assign count           = count_ff;
   assign status.empty    = is_empty;
   assign status.full     = is_full;
   assign status.rejected = rejected_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count exceeds the queue depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff < AW'(DEPTH) || AW'(DEPTH) == '0)
      else $error("front index outside the ring");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      op_valid && !is_full && (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK)
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted push did not grow the count");

   a_reject_edge: assert property (@(posedge clock) disable iff (reset)
      rejected_ff |-> (is_empty || is_full))
      else $error("refusal reported while neither empty nor full");

endmodule

// ----- rtl/double_ended_queue_unit.sv -----
// Top level of the double-ended queue unit: sequencer, slot RAM and response register.
//
// A bounded double-ended queue of item handles held in a ring of DEPTH slots.
// Request channel (req_): req_tuser carries the operation (push front, push back,
// pop front, pop back, status) and req_tdata the handle to push. Response
// channel (rsp_): one word per request with the front and back handles, the
// count and the empty, full and rejected flags after the operation.
// A push on a full queue or a pop on an empty one is refused: rejected is set
// and the queue is left as it was.
// From request to response: the accept cycle updates the pointers and writes
// the slot RAM, the next cycle (ST_READ) reads the front and back slots, and
// ST_LOAD loads the response register. One request is in flight at a time, so
// a new request is taken only after the last one has loaded its response.
// When the receiver stalls, the finished word waits in the response register
// and the next request is still taken and worked on; it waits in its last step
// until the register frees.
// Reset empties the queue and drops any pending response. Slot contents are
// not cleared; only written slots are ever read.
module double_ended_queue_unit #(
   parameter int DEPTH     = 16,
   parameter int ITEM_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // item[15:0]
   input  logic [2:0]  req_tuser,   // action[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // front_item[15:0], back_item[31:16], count[36:32], empty_res[37],
   // full_res[38], rejected[39]
   output logic [39:0] rsp_tdata
);
   import dqu_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   state_type      state_ff, state_in;
   logic           req_accept;
   logic           rsp_load;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [39:0]    rsp_data_ff, rsp_data_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        front_addr;
   logic [AW-1:0]        back_addr;
   logic [CW-1:0]        count;
   dqu_status_type       status;
   logic [ITEM_BITS-1:0] front_data;
   logic [ITEM_BITS-1:0] back_data;

   dqu_ptr #(
      .DEPTH(DEPTH)
   ) u_ptr (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (req_accept),
      .action    (action_type'(req_tuser)),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .front_addr(front_addr),
      .back_addr (back_addr),
      .count     (count),
      .status    (status)
   );

   dqu_ram #(
      .WIDTH(ITEM_BITS),
      .DEPTH(DEPTH)
   ) u_slots (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (ITEM_BITS'(req_tdata)),
      .rd_a_addr(front_addr),
      .rd_a_data(front_data),
      .rd_b_addr(back_addr),
      .rd_b_data(back_data)
   );

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_READ: begin
         end
         ST_LOAD: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   assign req_accept = req_tvalid && req_tready;

   // Response word; handles read as zero while the queue is empty.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in[15:0]  = status.empty ? '0 : OUT_ITEM_BITS'(front_data);
         rsp_data_in[31:16] = status.empty ? '0 : OUT_ITEM_BITS'(back_data);
         rsp_data_in[36:32] = OUT_COUNT_BITS'(count);
         rsp_data_in[37]    = status.empty;
         rsp_data_in[38]    = status.full;
         rsp_data_in[39]    = status.rejected;
         rsp_valid_in       = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready ##1 !req_tready)
      else $error("request taken while another is in flight");

   a_load_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_LOAD)
      else $error("slot read not followed by the load step");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_tvalid)
      else $error("response load did not raise valid");

endmodule

// ----- tb/sv/double_ended_queue_unit_checker.sv -----
// Checker of the double-ended queue unit: tracks the queue, predicts each response word and compares.
module double_ended_queue_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // item[15:0]
   input  logic [2:0]  req_tuser,   // action[2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // front_item[15:0], back_item[31:16], count[36:32], empty_res[37],
   // full_res[38], rejected[39]
   input  logic [39:0] rsp_tdata,
   output int          mismatch_count,
   output int          outstanding,
   output int          checked_count,
   output int          refused_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import dqu_pkg::*;

   localparam int DEPTH = 16;
   localparam int REPORT_LIMIT = 10;

   // Response word laid out as on rsp_tdata, lowest field last.
   typedef struct packed {
      logic                      rejected;
      logic                      full_res;
      logic                      empty_res;
      logic [OUT_COUNT_BITS-1:0] count;
      logic [OUT_ITEM_BITS-1:0]  back_item;
      logic [OUT_ITEM_BITS-1:0]  front_item;
   } deque_status_word_type;

   // Shadow copy of the ring, its front position and its fill level.
   logic [IN_ITEM_BITS-1:0] ring [DEPTH];
   logic [3:0]              head;
   logic [4:0]              fill;

   deque_status_word_type expected_words [$];

   // Applies one operation to the shadow queue and returns the status after it.
   function automatic deque_status_word_type apply_operation(input logic [2:0] action,
                                                             input logic [15:0] item);
      deque_status_word_type word;
      logic [3:0] pos;
      logic       refused;
      refused = 1'b0;
      case (action)
         ACT_PUSH_FRONT: begin
            if (fill >= DEPTH) begin
               refused = 1'b1;
            end else begin
               head = head - 4'd1;
               ring[head] = item;
               fill = fill + 5'd1;
            end
         end
         ACT_PUSH_BACK: begin
            if (fill >= DEPTH) begin
               refused = 1'b1;
            end else begin
               pos = head + fill[3:0];
               ring[pos] = item;
               fill = fill + 5'd1;
            end
         end
         ACT_POP_FRONT: begin
            if (fill == 0) begin
               refused = 1'b1;
            end else begin
               head = head + 4'd1;
               fill = fill - 5'd1;
            end
         end
         ACT_POP_BACK: begin
            if (fill == 0) begin
               refused = 1'b1;
            end else begin
               fill = fill - 5'd1;
            end
         end
         // Status and the unused codes leave the queue alone.
         default: begin
         end
      endcase
      if (fill == 0) begin
         word.front_item = '0;
         word.back_item  = '0;
      end else begin
         pos = head + fill[3:0] - 4'd1;
         word.front_item = ring[head];
         word.back_item  = ring[pos];
      end
      word.count     = fill;
      word.empty_res = (fill == 0);
      word.full_res  = (fill >= DEPTH);
      word.rejected  = refused;
      return word;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      checked_count  = 0;
      refused_count  = 0;
      head = '0;
      fill = '0;
   end

   // Responses are checked before the request of the same edge is predicted,
   // since a response can never belong to a request taken at that edge.
   always @(posedge clock) begin
      deque_status_word_type got;
      deque_status_word_type want;
      if (reset) begin
         head = '0;
         fill = '0;
         expected_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_words.size() == 0) begin
               note_mismatch($sformatf("response word %h with nothing expected", got));
            end else begin
               want = expected_words.pop_front();
               checked_count++;
               if (want.rejected) begin
                  refused_count++;
               end
               if (got.front_item !== want.front_item || got.back_item !== want.back_item ||
                   got.count !== want.count || got.empty_res !== want.empty_res ||
                   got.full_res !== want.full_res || got.rejected !== want.rejected) begin
                  note_mismatch($sformatf(
                     "front %h/%h back %h/%h count %0d/%0d empty %b/%b full %b/%b rej %b/%b",
                     want.front_item, got.front_item, want.back_item, got.back_item,
                     want.count, got.count, want.empty_res, got.empty_res,
                     want.full_res, got.full_res, want.rejected, got.rejected));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_words.push_back(apply_operation(req_tuser, req_tdata));
         end
      end
      outstanding = expected_words.size();
   end

endmodule

// ----- tb/sv/double_ended_queue_unit_test.sv -----
// Top of the double-ended queue unit testbench: clock, reset, stimulus and verdict.
module double_ended_queue_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dqu_pkg::*;

   localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
   localparam int DEPTH         = 16;
   localparam int IDLE_PCT      = 20;
   localparam int BURST_WORDS   = 100;
   localparam int BURSTS        = 7;
   localparam int HOLD_CYCLES   = 200;
   localparam int TAIL_CYCLES   = 8;
   localparam int CYCLE_LIMIT   = 200000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // item[15:0]
   logic [2:0]  req_tuser;   // action[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   // front_item[15:0], back_item[31:16], count[36:32], empty_res[37],
   // full_res[38], rejected[39]
   logic [39:0] rsp_tdata;

   int mismatch_count;
   int outstanding;
   int checked_count;
   int refused_count;
   int words_sent;
   int cycle_count;
   bit gaps_on;
   bit hold_request;

   double_ended_queue_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   double_ended_queue_unit_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count),
      .refused_count  (refused_count)
   );

   // Clock with a 4 ns period.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Watchdog on the total run length.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run exceeded %0d cycles with %0d words outstanding.", CYCLE_LIMIT,
                  outstanding);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: random idling, and a long hold-off when the sender asks for one.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready = gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
         end
      end
   end

   // Offers one word at a falling edge and returns at the falling edge after it is taken.
   task automatic offer_word(input logic [2:0] action, input logic [15:0] item);
      if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = action;
      req_tdata  = item;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   // Picks an operation: mostly pushes or pops by the given share, a little status and noise.
   function automatic logic [2:0] pick_action(input int push_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < 6) begin
         return 3'($urandom_range(ACT_UNUSED_LAST, ACT_STATUS));
      end else if ($urandom_range(99) < push_pct) begin
         return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      end else begin
         return $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
      end
   endfunction

   // Handles lean toward the all-zero and all-one extremes now and then.
   function automatic logic [15:0] pick_item();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         return 16'h0000;
      end else if (roll < 16) begin
         return 16'hFFFF;
      end else begin
         return 16'($urandom);
      end
   endfunction

   // Stimulus and verdict.
   initial begin
      int push_pct;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = ACT_STATUS;
      gaps_on      = 1'b1;
      hold_request = 1'b0;
      words_sent   = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty queue: status and refused pops.
      offer_word(ACT_STATUS, 16'hFFFF);
      offer_word(ACT_POP_FRONT, 16'h0000);
      offer_word(ACT_POP_BACK, 16'hFFFF);
      // Single element, front and back the same, then back to empty.
      offer_word(ACT_PUSH_FRONT, 16'hFFFF);
      offer_word(ACT_STATUS, 16'h0000);
      offer_word(ACT_POP_BACK, 16'h0000);
      // Fill to full from both ends so the back position wraps past the top of the ring.
      for (int k = 0; k < DEPTH; k++) begin
         offer_word((k % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, 16'((k << 12) | 16'h0A5C));
      end
      // Pushes on a full queue are refused.
      offer_word(ACT_PUSH_FRONT, 16'h0000);
      offer_word(ACT_PUSH_BACK, 16'hFFFF);
      // Unused codes behave as status only.
      for (int code = ACT_UNUSED_FIRST; code <= ACT_UNUSED_LAST; code++) begin
         offer_word(3'(code), pick_item());
      end

      // Random bursts alternating between filling, draining and balanced traffic.
      for (int burst = 0; burst < BURSTS; burst++) begin
         push_pct = (burst % 3 == 0) ? 80 : (burst % 3 == 1) ? 25 : 55;
         gaps_on  = (burst != 2);
         if (burst == 3) begin
            hold_request = 1'b1;
         end
         if (burst == 5) begin
            // Sender pauses until the block has answered everything.
            req_tvalid = 1'b0;
            while (outstanding != 0) @(negedge clock);
         end
         for (int n = 0; n < BURST_WORDS; n++) begin
            offer_word(pick_action(push_pct), pick_item());
         end
      end
      req_tvalid = 1'b0;
      gaps_on    = 1'b1;

      // Drain and let the pipeline settle.
      while (outstanding != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d request words; checked %0d response words, %0d of them refused.",
               words_sent, checked_count, refused_count);
      $display("Traffic mixed fill, drain and balanced bursts with a long receiver hold-off.");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d words outstanding.", mismatch_count, outstanding);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
